// File: hw/rtl/tpr_pkg.sv
// Shared types, constants and a helper function for the telemetry poll responder.
package tpr_pkg;

	// Slot and field geometry.
	localparam int unsigned SLOT_COUNT = 7;
	localparam int unsigned SLOT_W     = 3;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned WORD_W     = 32;
	localparam int unsigned ADDR_W     = 8;
	localparam int unsigned PERIOD_W   = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// Operation codes carried by an input transaction.
	typedef enum logic {
		OP_POLL   = 1'b0,
		OP_UPDATE = 1'b1
	} op_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SENSOR_ID        = 3'd0,
		CFG_LAT_LON_PERIOD   = 3'd1,
		CFG_ALTITUDE_PERIOD  = 3'd2,
		CFG_SPEED_PERIOD     = 3'd3,
		CFG_COURSE_PERIOD    = 3'd4,
		CFG_DATE_TIME_PERIOD = 3'd5
	} cfg_idx_t;

	// Data kinds reported in a frame.
	typedef enum logic [KIND_W-1:0] {
		KIND_LAT_LON   = 3'd0,
		KIND_ALTITUDE  = 3'd1,
		KIND_SPEED     = 3'd2,
		KIND_COURSE    = 3'd3,
		KIND_DATE_TIME = 3'd4
	} kind_t;

	// Slot numbers.
	localparam logic [SLOT_W-1:0] SLOT_LAT    = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_LON    = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_ALT    = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_SPEED  = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_COURSE = 3'd4;
	localparam logic [SLOT_W-1:0] SLOT_DATE   = 3'd5;
	localparam logic [SLOT_W-1:0] SLOT_LAST   = 3'(SLOT_COUNT - 1);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture the incoming transaction
		logic execute;  // apply the captured transaction to the state
	} tpr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_update;    // captured transaction is a slot update
		logic addr_match;   // captured poll addresses this sensor
		logic out_blocked;  // output register holds a result not being taken
	} tpr_status_t;

	// Map a slot to the kind of data it holds.
	function automatic kind_t slot_kind(input logic [SLOT_W-1:0] slot);
		kind_t kind;
		unique case (slot)
			SLOT_LAT, SLOT_LON: kind = KIND_LAT_LON;
			SLOT_ALT:           kind = KIND_ALTITUDE;
			SLOT_SPEED:         kind = KIND_SPEED;
			SLOT_COURSE:        kind = KIND_COURSE;
			default:            kind = KIND_DATE_TIME;
		endcase
		return kind;
	endfunction

endpackage

// File: hw/rtl/tpr_if.sv
// Channel interfaces: input transactions, result transactions and configuration writes.
interface tpr_in_if;
	logic                          valid;
	logic                          ready;
	logic                          operation;
	logic [tpr_pkg::ADDR_W-1:0]    poll_address;
	logic [tpr_pkg::WORD_W-1:0]    now_ms;
	logic [tpr_pkg::SLOT_W-1:0]    update_slot;
	logic [tpr_pkg::WORD_W-1:0]    update_word;

	modport source (
		output valid, operation, poll_address, now_ms, update_slot, update_word,
		input  ready
	);
	modport sink (
		input  valid, operation, poll_address, now_ms, update_slot, update_word,
		output ready
	);
endinterface

interface tpr_out_if;
	logic                          valid;
	logic                          ready;
	logic                          has_data;
	logic [tpr_pkg::KIND_W-1:0]    data_kind;
	logic [tpr_pkg::WORD_W-1:0]    value;

	modport source (
		output valid, has_data, data_kind, value,
		input  ready
	);
	modport sink (
		input  valid, has_data, data_kind, value,
		output ready
	);
endinterface

interface tpr_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tpr_pkg::CFG_IDX_W-1:0] index;
	logic [tpr_pkg::PERIOD_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// File: hw/rtl/tpr_datapath.sv
// Datapath: configuration registers, slot store, deadline check and the output register.
module tpr_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       operation,
	input  logic [tpr_pkg::ADDR_W-1:0] poll_address,
	input  logic [tpr_pkg::WORD_W-1:0] now_ms,
	input  logic [tpr_pkg::SLOT_W-1:0] update_slot,
	input  logic [tpr_pkg::WORD_W-1:0] update_word,
	input  tpr_pkg::tpr_cmd_t          cmd,
	output tpr_pkg::tpr_status_t       status,
	tpr_cfg_if.sink                    cfg,
	tpr_out_if.source                  result
);

	// Configuration registers.
	logic [tpr_pkg::ADDR_W-1:0]   sensor_id_q;
	logic [tpr_pkg::PERIOD_W-1:0] lat_lon_period_q;
	logic [tpr_pkg::PERIOD_W-1:0] altitude_period_q;
	logic [tpr_pkg::PERIOD_W-1:0] speed_period_q;
	logic [tpr_pkg::PERIOD_W-1:0] course_period_q;
	logic [tpr_pkg::PERIOD_W-1:0] date_time_period_q;

	// Captured transaction.
	logic                         operation_q;
	logic [tpr_pkg::ADDR_W-1:0]   poll_address_q;
	logic [tpr_pkg::WORD_W-1:0]   now_ms_q;
	logic [tpr_pkg::SLOT_W-1:0]   update_slot_q;
	logic [tpr_pkg::WORD_W-1:0]   update_word_q;

	// Sensor state.
	logic [tpr_pkg::SLOT_W-1:0]   slot_index_q;
	logic [tpr_pkg::WORD_W-1:0]   deadlines_q  [tpr_pkg::SLOT_COUNT];
	logic [tpr_pkg::WORD_W-1:0]   data_words_q [tpr_pkg::SLOT_COUNT];

	// Output register.
	logic                         out_valid_q;
	logic                         out_has_data_q;
	logic [tpr_pkg::KIND_W-1:0]   out_kind_q;
	logic [tpr_pkg::WORD_W-1:0]   out_value_q;

	// Poll evaluation for the current slot.
	tpr_pkg::kind_t               kind;
	logic [tpr_pkg::PERIOD_W-1:0] period;
	logic                         is_poll_hit;
	logic                         send;
	logic [tpr_pkg::WORD_W-1:0]   next_deadline;
	logic [tpr_pkg::SLOT_W-1:0]   next_slot;
	logic                         update_valid;

	assign cfg.ready = 1'b1;

	// Configuration writes; indexes beyond the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sensor_id_q        <= '0;
			lat_lon_period_q   <= 16'd1000;
			altitude_period_q  <= 16'd500;
			speed_period_q     <= 16'd500;
			course_period_q    <= 16'd500;
			date_time_period_q <= 16'd10000;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				tpr_pkg::CFG_SENSOR_ID:        sensor_id_q        <= cfg.data[tpr_pkg::ADDR_W-1:0];
				tpr_pkg::CFG_LAT_LON_PERIOD:   lat_lon_period_q   <= cfg.data;
				tpr_pkg::CFG_ALTITUDE_PERIOD:  altitude_period_q  <= cfg.data;
				tpr_pkg::CFG_SPEED_PERIOD:     speed_period_q     <= cfg.data;
				tpr_pkg::CFG_COURSE_PERIOD:    course_period_q    <= cfg.data;
				tpr_pkg::CFG_DATE_TIME_PERIOD: date_time_period_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			operation_q    <= operation;
			poll_address_q <= poll_address;
			now_ms_q       <= now_ms;
			update_slot_q  <= update_slot;
			update_word_q  <= update_word;
		end
	end

	// Status toward the controller.
	assign status.is_update   = (operation_q == tpr_pkg::OP_UPDATE);
	assign status.addr_match  = (poll_address_q == sensor_id_q);
	assign status.out_blocked = out_valid_q && !result.ready;

	// Period of the current slot's kind.
	assign kind = tpr_pkg::slot_kind(slot_index_q);
	always_comb begin
		unique case (kind)
			tpr_pkg::KIND_LAT_LON:  period = lat_lon_period_q;
			tpr_pkg::KIND_ALTITUDE: period = altitude_period_q;
			tpr_pkg::KIND_SPEED:    period = speed_period_q;
			tpr_pkg::KIND_COURSE:   period = course_period_q;
			default:                period = date_time_period_q;
		endcase
	end

	// A frame carries data only when the poll time is strictly past the deadline.
	assign is_poll_hit   = cmd.execute && !status.is_update && status.addr_match;
	assign send          = now_ms_q > deadlines_q[slot_index_q];
	assign next_deadline = now_ms_q + {{(tpr_pkg::WORD_W - tpr_pkg::PERIOD_W){1'b0}}, period};
	assign next_slot     = (slot_index_q == tpr_pkg::SLOT_LAST) ? '0 : slot_index_q + 3'd1;
	assign update_valid  = cmd.execute && status.is_update
		&& (update_slot_q <= tpr_pkg::SLOT_LAST);

	// Slot pointer, deadlines and stored words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_index_q <= '0;
			for (int i = 0; i < tpr_pkg::SLOT_COUNT; i++) begin
				deadlines_q[i]  <= '0;
				data_words_q[i] <= '0;
			end
		end else begin
			if (update_valid) begin
				data_words_q[update_slot_q] <= update_word_q;
			end
			if (is_poll_hit) begin
				slot_index_q <= next_slot;
				if (send) begin
					deadlines_q[slot_index_q] <= next_deadline;
				end
			end
		end
	end

	// Output register: loads on a served poll, clears when the transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_poll_hit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (is_poll_hit) begin
			out_has_data_q <= send;
			out_kind_q     <= kind;
			out_value_q    <= send ? data_words_q[slot_index_q] : '0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.has_data  = out_has_data_q;
	assign result.data_kind = out_kind_q;
	assign result.value     = out_value_q;

endmodule

// File: hw/rtl/tpr_controller.sv
// Controller: sequences capture and execution of one transaction at a time.
module tpr_controller (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  tpr_pkg::tpr_status_t status,
	output tpr_pkg::tpr_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   produces;

	// A poll to this address yields a frame and must find the output register free.
	assign produces = !status.is_update && status.addr_match;

	always_comb begin
		state_next  = state_q;
		in_ready    = 1'b0;
		cmd.load    = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!(produces && status.out_blocked)) begin
					cmd.execute = 1'b1;
					state_next  = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

// File: hw/rtl/telemetry_poll_responder_core.sv
// Top level of the telemetry poll responder: controller plus datapath.
//
// Usage:
// The item channel carries polls and slot updates. A poll whose address equals
// the configured sensor id serves the current slot round-robin over seven slots
// and yields one result transaction; other polls and all updates yield none.
// The cfg channel writes the sensor id and the per-kind periods and is always
// ready. The user writes it only while the block is idle; the block does not check.
// Timing:
// An item is captured in the idle state; the execute state then compares
// the poll time with the slot deadline, adds the period and loads the output
// register. The result is valid the cycle after execution, and a new item is
// accepted only once the previous one has executed. A finished result waits
// in the output register while the next item is captured; if the receiver
// still stalls when that item would produce another result, execution holds
// until the register is taken.
// Reset:
// arst_n clears the slot pointer, deadlines and stored words to zero and loads
// the default periods; no result is pending after reset.
module telemetry_poll_responder_core (
	input  logic       clk,
	input  logic       arst_n,
	tpr_in_if.sink     item,
	tpr_out_if.source  result,
	tpr_cfg_if.sink    cfg
);

	tpr_pkg::tpr_cmd_t    cmd;
	tpr_pkg::tpr_status_t status;
	logic                 in_ready;

	assign item.ready = in_ready;

	// Sequencing.
	tpr_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// State and arithmetic.
	tpr_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (item.operation),
		.poll_address (item.poll_address),
		.now_ms       (item.now_ms),
		.update_slot  (item.update_slot),
		.update_word  (item.update_word),
		.cmd          (cmd),
		.status       (status),
		.cfg          (cfg),
		.result       (result)
	);

endmodule
